// File: hdl/mbdt_pkg.sv
// ----------------------------------------------------------------------------
// Button debounce timer package
// Shared constants and types for the multi-button debounce timer core.
// ----------------------------------------------------------------------------
package mbdt_pkg;

  localparam int unsigned PIN_SLOTS        = 16;
  localparam int unsigned BUTTON_COUNT_DEF = 16;
  localparam int unsigned PIN_W            = 4;
  localparam int unsigned CNT_W            = 5;
  localparam int unsigned TIME_W           = 32;
  localparam int unsigned MASK_W           = 16;
  localparam logic [TIME_W-1:0] DEBOUNCE_RESET = 32'd20000;

  typedef enum logic {
    REQ_EDGE = 1'b0,
    REQ_ACK  = 1'b1
  } req_type_e;

  typedef enum logic {
    CFG_DEBOUNCE = 1'b0,
    CFG_ENABLE   = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    F_IDLE,
    F_SCAN,
    F_POST
  } front_state_e;

  typedef enum logic {
    B_IDLE,
    B_EMIT
  } back_state_e;

  typedef struct packed {
    logic [PIN_W-1:0]  button;
    logic [TIME_W-1:0] press_us;
  } rel_rec_t;

  typedef struct packed {
    logic              valid;
    logic [CNT_W-1:0]  count;
    logic [MASK_W-1:0] edge_mask;
  } batch_t;

  typedef struct packed {
    logic              release_valid;
    logic [PIN_W-1:0]  button;
    logic [TIME_W-1:0] press_us;
    logic [MASK_W-1:0] edge_mask;
    logic              last;
  } res_t;

endpackage

// File: hdl/mbdt_if.sv
// ----------------------------------------------------------------------------
// Button debounce timer channels
// Valid/ready request and result channels of the debounce timer core.
// ----------------------------------------------------------------------------
interface mbdt_req_if;
  logic                        valid;
  logic                        ready;
  logic                        req_type;
  logic [mbdt_pkg::MASK_W-1:0] pending_mask;
  logic [mbdt_pkg::TIME_W-1:0] now_us;
  logic [mbdt_pkg::PIN_W-1:0]  ack_button;

  modport source (output valid, req_type, pending_mask, now_us, ack_button, input ready);
  modport sink (input valid, req_type, pending_mask, now_us, ack_button, output ready);
endinterface

interface mbdt_res_if;
  logic                        valid;
  logic                        ready;
  logic                        release_valid;
  logic [mbdt_pkg::PIN_W-1:0]  button;
  logic [mbdt_pkg::TIME_W-1:0] press_us;
  logic [mbdt_pkg::MASK_W-1:0] edge_mask;
  logic                        last;

  modport source (output valid, release_valid, button, press_us, edge_mask, last,
                  input ready);
  modport sink (input valid, release_valid, button, press_us, edge_mask, last,
                output ready);
endinterface

// File: hdl/mbdt_front.sv
// ----------------------------------------------------------------------------
// Button debounce timer front end
// Accepts requests, holds the per-pin state and scans one pin per cycle unless the release queue is full.
// ----------------------------------------------------------------------------
module mbdt_front #(
  parameter int unsigned BUTTON_COUNT = mbdt_pkg::BUTTON_COUNT_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  mbdt_req_if.sink                    req,
  input  logic                        cfg_we_i,
  input  mbdt_pkg::cfg_idx_e          cfg_idx_i,
  input  logic [mbdt_pkg::TIME_W-1:0] cfg_data_i,
  output mbdt_pkg::rel_rec_t          push_rec_o,
  output logic                        push_o,
  input  logic                        q_full_i,
  output mbdt_pkg::batch_t            batch_o,
  input  logic                        batch_take_i
);
  import mbdt_pkg::*;

  localparam int unsigned PinCount = (BUTTON_COUNT > PIN_SLOTS) ? PIN_SLOTS : BUTTON_COUNT;
  localparam int unsigned IdxW     = (PinCount > 1) ? $clog2(PinCount) : 1;

  logic [TIME_W-1:0] press_q [PinCount];
  logic [PinCount-1:0] wait_q;
  logic [TIME_W-1:0] debounce_q;
  logic [MASK_W-1:0] enable_q;

  front_state_e      state_q, state_d;
  logic [IdxW-1:0]   idx_q, idx_d;
  logic [MASK_W-1:0] pend_q, pend_d;
  logic [TIME_W-1:0] now_q, now_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  batch_t            batch_q, batch_d;

  logic [TIME_W-1:0] cur_press;
  logic [TIME_W-1:0] due_time;
  logic [MASK_W-1:0] edge_mask;
  logic              bit_on, is_empty, is_rel, stall, accept, ack_in_range;

  assign cur_press    = press_q[idx_q];
  assign due_time     = cur_press + debounce_q;
  assign bit_on       = pend_q[idx_q] & enable_q[idx_q];
  assign is_empty     = (cur_press == '0);
  assign is_rel       = (due_time < now_q);
  assign stall        = bit_on & ~is_empty & is_rel & q_full_i;
  assign accept       = req.valid & req.ready;
  assign ack_in_range = (32'(req.ack_button) < PinCount);

  always_comb begin
    edge_mask = '0;
    edge_mask[PinCount-1:0] = wait_q;
  end

  assign push_rec_o = '{button: PIN_W'(idx_q), press_us: now_q - cur_press};
  assign batch_o    = batch_q;

  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    pend_d    = pend_q;
    now_d     = now_q;
    cnt_d     = cnt_q;
    batch_d   = batch_q;
    push_o    = 1'b0;
    req.ready = (state_q == F_IDLE) && !batch_q.valid;
    if (batch_take_i) begin
      batch_d.valid = 1'b0;
    end
    case (state_q)
      F_IDLE: begin
        if (req.valid && req.ready) begin
          pend_d  = req.pending_mask;
          now_d   = req.now_us;
          cnt_d   = '0;
          idx_d   = '0;
          state_d = (req.req_type == REQ_ACK) ? F_POST : F_SCAN;
        end
      end
      F_SCAN: begin
        if (!stall) begin
          push_o = bit_on & ~is_empty & is_rel;
          if (push_o) begin
            cnt_d = cnt_q + CNT_W'(1);
          end
          if (idx_q == IdxW'(PinCount - 1)) begin
            state_d = F_POST;
          end else begin
            idx_d = idx_q + IdxW'(1);
          end
        end
      end
      F_POST: begin
        batch_d = '{valid: 1'b1, count: cnt_q, edge_mask: edge_mask};
        state_d = F_IDLE;
      end
      default: begin
        state_d = F_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      idx_q   <= '0;
      cnt_q   <= '0;
      batch_q <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      cnt_q   <= cnt_d;
      batch_q <= batch_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
    now_q  <= now_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < PinCount; i++) begin
        press_q[i] <= '0;
      end
      wait_q     <= '0;
      debounce_q <= DEBOUNCE_RESET;
      enable_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_DEBOUNCE: begin
            debounce_q <= cfg_data_i;
          end
          CFG_ENABLE: begin
            for (int i = 0; i < PinCount; i++) begin
              if (cfg_data_i[i] && !enable_q[i]) begin
                press_q[i] <= '0;
                wait_q[i]  <= 1'b0;
              end
            end
            enable_q <= cfg_data_i[MASK_W-1:0];
          end
          default: begin
          end
        endcase
      end
      if (accept && (req.req_type == REQ_ACK) && ack_in_range) begin
        press_q[req.ack_button[IdxW-1:0]] <= '0;
      end
      if ((state_q == F_SCAN) && bit_on && !stall) begin
        if (is_empty) begin
          press_q[idx_q] <= now_q;
          wait_q[idx_q]  <= 1'b1;
        end else if (is_rel) begin
          press_q[idx_q] <= now_q - cur_press;
          wait_q[idx_q]  <= 1'b0;
        end else begin
          wait_q[idx_q] <= 1'b1;
        end
      end
    end
  end

endmodule

// File: hdl/mbdt_queue.sv
// ----------------------------------------------------------------------------
// Button debounce timer release queue
// Small FIFO of release records between the front end and the result side.
// ----------------------------------------------------------------------------
module mbdt_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  mbdt_pkg::rel_rec_t push_rec_i,
  input  logic               pop_i,
  output mbdt_pkg::rel_rec_t pop_rec_o,
  output logic               full_o,
  output logic               empty_o
);
  import mbdt_pkg::*;

  rel_rec_t         mem_q [PIN_SLOTS];
  logic [PIN_W-1:0] wr_q, rd_q;
  logic [CNT_W-1:0] cnt_q;
  logic             do_push, do_pop;

  assign full_o    = (cnt_q == CNT_W'(PIN_SLOTS));
  assign empty_o   = (cnt_q == '0);
  assign do_push   = push_i & ~full_o;
  assign do_pop    = pop_i & ~empty_o;
  assign pop_rec_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_rec_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= wr_q + PIN_W'(1);
      end
      if (do_pop) begin
        rd_q <= rd_q + PIN_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

endmodule

// File: hdl/mbdt_back.sv
// ----------------------------------------------------------------------------
// Button debounce timer result side
// Turns a finished batch and its queued releases into result requests.
// ----------------------------------------------------------------------------
module mbdt_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mbdt_pkg::batch_t   batch_i,
  output logic               batch_take_o,
  input  mbdt_pkg::rel_rec_t q_rec_i,
  input  logic               q_empty_i,
  output logic               pop_o,
  mbdt_res_if.source         res
);
  import mbdt_pkg::*;

  back_state_e       state_q, state_d;
  logic [CNT_W-1:0]  left_q, left_d;
  logic [MASK_W-1:0] mask_q, mask_d;
  res_t              out_q, out_d;
  logic              out_valid_q, out_valid_d;
  logic              out_free, out_load;

  assign out_free = ~out_valid_q | res.ready;

  always_comb begin
    state_d      = state_q;
    left_d       = left_q;
    mask_d       = mask_q;
    out_d        = out_q;
    out_load     = 1'b0;
    batch_take_o = 1'b0;
    pop_o        = 1'b0;
    case (state_q)
      B_IDLE: begin
        if (batch_i.valid && out_free) begin
          batch_take_o = 1'b1;
          if (batch_i.count == '0) begin
            out_load = 1'b1;
            out_d    = '{release_valid: 1'b0, button: '0, press_us: '0,
                         edge_mask: batch_i.edge_mask, last: 1'b1};
          end else begin
            left_d  = batch_i.count;
            mask_d  = batch_i.edge_mask;
            state_d = B_EMIT;
          end
        end
      end
      B_EMIT: begin
        if (out_free && !q_empty_i) begin
          pop_o    = 1'b1;
          out_load = 1'b1;
          out_d    = '{release_valid: 1'b1, button: q_rec_i.button,
                       press_us: q_rec_i.press_us, edge_mask: mask_q,
                       last: (left_q == CNT_W'(1))};
          left_d   = left_q - CNT_W'(1);
          if (left_q == CNT_W'(1)) begin
            state_d = B_IDLE;
          end
        end
      end
      default: begin
        state_d = B_IDLE;
      end
    endcase
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (res.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      left_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      left_q      <= left_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mask_q <= mask_d;
    out_q  <= out_d;
  end

  assign res.valid         = out_valid_q;
  assign res.release_valid = out_q.release_valid;
  assign res.button        = out_q.button;
  assign res.press_us      = out_q.press_us;
  assign res.edge_mask     = out_q.edge_mask;
  assign res.last          = out_q.last;

endmodule

// File: hdl/multi_button_debounce_timer_core.sv
// Edge events scan min(BUTTON_COUNT, 16) pins, one per cycle unless the release queue is
// full; the batch is registered after the scan and the results after the result side
// takes it. An acknowledge skips the scan and gives a single result.
// Results leave one per cycle while the consumer is ready; the next request is taken in
// the cycle after the result side takes the batch.
// Reset clears all press times and wait flags, sets debounce to 20000 and disables pins.
// ----------------------------------------------------------------------------
// Multi-button debounce timer core
// Debounces active-low buttons and reports press lengths on release.
// ----------------------------------------------------------------------------
module multi_button_debounce_timer_core #(
  parameter int unsigned BUTTON_COUNT = mbdt_pkg::BUTTON_COUNT_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  mbdt_req_if.sink                    req_i,
  mbdt_res_if.source                  res_o,
  input  logic                        cfg_we_i,
  input  mbdt_pkg::cfg_idx_e          cfg_idx_i,
  input  logic [mbdt_pkg::TIME_W-1:0] cfg_data_i
);
  import mbdt_pkg::*;

  rel_rec_t push_rec, pop_rec;
  batch_t   batch;
  logic     push, pop, q_full, q_empty, batch_take;

  mbdt_front #(
    .BUTTON_COUNT(BUTTON_COUNT)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req         (req_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .push_rec_o  (push_rec),
    .push_o      (push),
    .q_full_i    (q_full),
    .batch_o     (batch),
    .batch_take_i(batch_take)
  );

  mbdt_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .push_rec_i(push_rec),
    .pop_i     (pop),
    .pop_rec_o (pop_rec),
    .full_o    (q_full),
    .empty_o   (q_empty)
  );

  mbdt_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .batch_i     (batch),
    .batch_take_o(batch_take),
    .q_rec_i     (pop_rec),
    .q_empty_i   (q_empty),
    .pop_o       (pop),
    .res         (res_o)
  );

endmodule
